### sv/lias_pkg.sv
// Shared types, constants and helpers for the linear-interpolation resampler.
package lias_pkg;

  localparam int PHASE_BITS  = 30;
  localparam int INTERP_BITS = 15;
  localparam int MAX_OUTPUTS = 8;
  localparam int CNT_W       = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int SKIP_W      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_SHIFT  = 12;
  localparam int MUL_W       = SAMPLE_W + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUTPUTS - 1);

  // register indexes, byte address = 4 * index
  localparam logic [1:0] REG_PHASE_INC = 2'd0;
  localparam logic [1:0] REG_MONO      = 2'd1;
  localparam logic [1:0] REG_VOL_L     = 2'd2;
  localparam logic [1:0] REG_VOL_R     = 2'd3;

  localparam logic [31:0] PHASE_INC_RESET = 32'h4000_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last_output;
  } out_word_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_LERP_L  = 6'b000010,
    ST_LERP_R  = 6'b000100,
    ST_SCALE_L = 6'b001000,
    ST_SCALE_R = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  // floor shift of a gain product and clamp to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] sat_scale(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> GAIN_SHIFT;
    if (s > PROD_W'(signed'(32'sd32767)))
      sat_scale = 16'sh7FFF;
    else if (s < -(PROD_W'(signed'(32'sd32768))))
      sat_scale = 16'sh8000;
    else
      sat_scale = s[SAMPLE_W-1:0];
  endfunction

endpackage

### sv/lias_mul.sv
// Shared signed multiplier with registered product.
module lias_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [lias_pkg::MUL_W-1:0]   a,
  input  logic signed [lias_pkg::MUL_W-1:0]   b,
  output logic signed [lias_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

### sv/linear_interp_audio_resampler_top.sv
// Linear-interpolation audio resampler: config port, sequencer and output register.
// A frame that is only skipped is taken without leaving idle and yields no word. A frame that
// the phase reaches yields n output words (1 to 8); each output word goes through the states
// LERP_L, LERP_R, SCALE_L, SCALE_R and EMIT: four passes through the one shared 17x17 multiplier
// (left and right interpolation, left and right gain) plus an emit step, and EMIT waits while
// the output side stalls. in_stall is high until such a frame is done.
module linear_interp_audio_resampler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lias_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lias_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lias_pkg::APB_AW-1:0]   paddr,
  input  logic [lias_pkg::APB_DW-1:0]   pwdata,
  output logic [lias_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  // configuration
  logic [31:0]                               phase_inc;
  logic                                      mono;
  logic signed [lias_pkg::SAMPLE_W-1:0]      vol_l;
  logic signed [lias_pkg::SAMPLE_W-1:0]      vol_r;

  // stream state
  lias_pkg::state_t                          state;
  logic signed [lias_pkg::SAMPLE_W-1:0]      prev_l;
  logic signed [lias_pkg::SAMPLE_W-1:0]      prev_r;
  logic signed [lias_pkg::SAMPLE_W-1:0]      cur_l;
  logic signed [lias_pkg::SAMPLE_W-1:0]      cur_r;
  logic [lias_pkg::PHASE_BITS-1:0]           phase;
  logic [lias_pkg::SKIP_W-1:0]               skip;
  logic [lias_pkg::CNT_W-1:0]                cnt;
  logic signed [lias_pkg::SAMPLE_W-1:0]      sl;
  logic signed [lias_pkg::SAMPLE_W-1:0]      sr;
  logic signed [lias_pkg::SAMPLE_W-1:0]      res_l;

  logic                                      cfg_wr;
  logic                                      in_go;
  logic [lias_pkg::SKIP_W-1:0]               skip_eff;
  logic [lias_pkg::SKIP_W-1:0]               skip_dec;
  logic                                      emit_go;
  logic [lias_pkg::PHASE_BITS+2:0]           acc;
  logic [lias_pkg::SKIP_W-1:0]               carry;
  logic                                      last_flag;

  logic                                      mul_en;
  logic signed [lias_pkg::MUL_W-1:0]         mul_a;
  logic signed [lias_pkg::MUL_W-1:0]         mul_b;
  logic signed [lias_pkg::PROD_W-1:0]        prod;
  logic signed [lias_pkg::MUL_W-1:0]         diff_l;
  logic signed [lias_pkg::MUL_W-1:0]         diff_r;
  logic signed [lias_pkg::MUL_W-1:0]         frac_op;
  logic signed [lias_pkg::PROD_W-1:0]        prod_sh;
  logic signed [lias_pkg::SAMPLE_W+1:0]      lerp_l;
  logic signed [lias_pkg::SAMPLE_W+1:0]      lerp_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc <= lias_pkg::PHASE_INC_RESET;
      mono      <= 1'b0;
      vol_l     <= '0;
      vol_r     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lias_pkg::REG_PHASE_INC: phase_inc <= pwdata;
        lias_pkg::REG_MONO:      mono      <= pwdata[0];
        lias_pkg::REG_VOL_L:     vol_l     <= pwdata[lias_pkg::SAMPLE_W-1:0];
        lias_pkg::REG_VOL_R:     vol_r     <= pwdata[lias_pkg::SAMPLE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lias_pkg::REG_PHASE_INC: prdata = phase_inc;
      lias_pkg::REG_MONO:      prdata = {31'd0, mono};
      lias_pkg::REG_VOL_L:     prdata = {16'd0, vol_l};
      lias_pkg::REG_VOL_R:     prdata = {16'd0, vol_r};
    endcase
  end

  // ---------------- shared multiplier ----------------
  assign diff_l  = {cur_l[lias_pkg::SAMPLE_W-1], cur_l} - {prev_l[lias_pkg::SAMPLE_W-1], prev_l};
  assign diff_r  = {cur_r[lias_pkg::SAMPLE_W-1], cur_r} - {prev_r[lias_pkg::SAMPLE_W-1], prev_r};
  assign frac_op = lias_pkg::MUL_W'(phase[lias_pkg::PHASE_BITS-1:
                                          lias_pkg::PHASE_BITS-lias_pkg::INTERP_BITS]);

  always_comb begin
    mul_en = 1'b1;
    unique case (state)
      lias_pkg::ST_LERP_L: begin
        mul_a = diff_l;
        mul_b = frac_op;
      end
      lias_pkg::ST_LERP_R: begin
        mul_a = diff_r;
        mul_b = frac_op;
      end
      lias_pkg::ST_SCALE_L: begin
        mul_a = {vol_l[lias_pkg::SAMPLE_W-1], vol_l};
        mul_b = {sl[lias_pkg::SAMPLE_W-1], sl};
      end
      lias_pkg::ST_SCALE_R: begin
        mul_a = {vol_r[lias_pkg::SAMPLE_W-1], vol_r};
        mul_b = {sr[lias_pkg::SAMPLE_W-1], sr};
      end
      default: begin
        // idle and emit: keep the right-channel gain product
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  lias_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign prod_sh = prod >>> lias_pkg::INTERP_BITS;
  assign lerp_l  = {{2{prev_l[lias_pkg::SAMPLE_W-1]}}, prev_l} + prod_sh[lias_pkg::SAMPLE_W+1:0];
  assign lerp_r  = {{2{prev_r[lias_pkg::SAMPLE_W-1]}}, prev_r} + prod_sh[lias_pkg::SAMPLE_W+1:0];

  // ---------------- sequencer ----------------
  assign in_stall = (state != lias_pkg::ST_IDLE);
  assign in_go    = in_valid & ~in_stall;
  assign skip_eff = (skip == '0) ? lias_pkg::SKIP_W'(1) : skip;
  assign skip_dec = skip_eff - lias_pkg::SKIP_W'(1);

  assign acc       = {3'b000, phase} + {1'b0, phase_inc};
  assign carry     = acc[lias_pkg::PHASE_BITS+2:lias_pkg::PHASE_BITS];
  assign last_flag = (carry != '0) || (cnt == lias_pkg::CNT_LAST);
  assign emit_go   = (state == lias_pkg::ST_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lias_pkg::ST_IDLE;
      prev_l <= '0;
      prev_r <= '0;
      phase  <= '0;
      skip   <= lias_pkg::SKIP_W'(1);
      cnt    <= '0;
    end else begin
      unique case (state)
        lias_pkg::ST_IDLE: begin
          if (in_go) begin
            if (skip_dec != '0) begin
              skip   <= skip_dec;
              prev_l <= in_data.left_sample;
              prev_r <= in_data.right_sample;
            end else begin
              skip  <= '0;
              cnt   <= '0;
              state <= lias_pkg::ST_LERP_L;
            end
          end
        end
        lias_pkg::ST_LERP_L:  state <= lias_pkg::ST_LERP_R;
        lias_pkg::ST_LERP_R:  state <= lias_pkg::ST_SCALE_L;
        lias_pkg::ST_SCALE_L: state <= lias_pkg::ST_SCALE_R;
        lias_pkg::ST_SCALE_R: state <= lias_pkg::ST_EMIT;
        lias_pkg::ST_EMIT: begin
          if (emit_go) begin
            phase <= acc[lias_pkg::PHASE_BITS-1:0];
            cnt   <= cnt + lias_pkg::CNT_W'(1);
            // cap hit inside the interval: move on to the next frame
            skip  <= (carry == '0) ? lias_pkg::SKIP_W'(1) : carry;
            if (last_flag) begin
              prev_l <= cur_l;
              prev_r <= cur_r;
              state  <= lias_pkg::ST_IDLE;
            end else begin
              state  <= lias_pkg::ST_LERP_L;
            end
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      cur_l <= in_data.left_sample;
      cur_r <= in_data.right_sample;
    end
    if (state == lias_pkg::ST_LERP_R) begin
      sl <= lerp_l[lias_pkg::SAMPLE_W-1:0];
    end
    if (state == lias_pkg::ST_SCALE_L) begin
      sr <= mono ? sl : lerp_r[lias_pkg::SAMPLE_W-1:0];
    end
    if (state == lias_pkg::ST_SCALE_R) begin
      res_l <= lias_pkg::sat_scale(prod);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data.left_out    <= res_l;
      out_data.right_out   <= lias_pkg::sat_scale(prod);
      out_data.last_output <= last_flag;
    end
  end

  // ---------------- assertions ----------------
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (emit_go && last_flag) |=> (state == lias_pkg::ST_IDLE && skip != '0))
    else $error("last word did not end the frame");

  a_phase_moves_on_emit: assert property (@(posedge clk) disable iff (rst)
    !emit_go |=> $stable(phase))
    else $error("phase changed without an output word");

  a_cap_forces_last: assert property (@(posedge clk) disable iff (rst)
    (emit_go && cnt == lias_pkg::CNT_LAST) |=> out_data.last_output)
    else $error("output cap reached without last mark");

  a_idle_no_pending_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (state == lias_pkg::ST_IDLE && $past(state) == lias_pkg::ST_EMIT) |-> skip != '0)
    else $error("frame closed with a zero skip count");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the linear-interpolation audio resampler top level.
module tb_top;
  import lias_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_TAIL      = 8;
  localparam int RAND_PER_PHASE = 21;
  localparam int N_RAND_PHASES  = 7;
  localparam int N_CORNER       = 24;

  typedef struct {
    logic [31:0] inc;
    logic        mono;
    logic [15:0] gain_l;
    logic [15:0] gain_r;
  } setting_t;

  // Tracks the resampler state and the output words each frame is due to produce.
  class resample_tracker;
    logic [31:0] phase_inc;
    logic        mono;
    int          gain_l, gain_r;
    int          prev_l, prev_r;
    logic [PHASE_BITS-1:0] phase;
    logic [SKIP_W-1:0]     skip;
    out_word_t   due_frames[$];
    int          mismatches;

    function new();
      phase_inc  = PHASE_INC_RESET;
      mono       = 1'b0;
      gain_l     = 0;
      gain_r     = 0;
      prev_l     = 0;
      prev_r     = 0;
      phase      = '0;
      skip       = SKIP_W'(1);
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_PHASE_INC: phase_inc = val;
        REG_MONO:      mono = val[0];
        REG_VOL_L:     gain_l = int'($signed(val[15:0]));
        REG_VOL_R:     gain_r = int'($signed(val[15:0]));
        default: ;
      endcase
    endfunction

    function int interp(int a, int b);
      longint d, f;
      d = longint'(b) - longint'(a);
      f = longint'(phase >> (PHASE_BITS - INTERP_BITS));
      return a + int'((d * f) >>> INTERP_BITS);
    endfunction

    function logic signed [15:0] gain_clamp(int gain, int s);
      longint v;
      v = (longint'(gain) * longint'(s)) >>> GAIN_SHIFT;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void take_frame(in_word_t w);
      int cur_l, cur_r, sl, sr, n;
      logic [PHASE_BITS+2:0] acc;
      out_word_t o;
      cur_l = int'($signed(w.left_sample));
      cur_r = int'($signed(w.right_sample));
      n = 0;
      if (skip == 0) skip = SKIP_W'(1);
      skip = skip - 1'b1;
      while (skip == 0 && n < MAX_OUTPUTS) begin
        sl = interp(prev_l, cur_l);
        sr = mono ? sl : interp(prev_r, cur_r);
        o.left_out  = gain_clamp(gain_l, sl);
        o.right_out = gain_clamp(gain_r, sr);
        n++;
        acc   = {3'b000, phase} + {1'b0, phase_inc};
        skip  = SKIP_W'(skip + acc[PHASE_BITS+2:PHASE_BITS]);
        phase = acc[PHASE_BITS-1:0];
        o.last_output = (skip != 0) || (n == MAX_OUTPUTS);
        due_frames.push_back(o);
      end
      // cap reached with the phase still inside this interval: move on anyway
      if (skip == 0) skip = SKIP_W'(1);
      prev_l = cur_l;
      prev_r = cur_r;
    endfunction

    function void match_output(out_word_t got);
      out_word_t exp_w;
      if (due_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output word with none due: L=%0d R=%0d last=%0b",
                   $signed(got.left_out), $signed(got.right_out), got.last_output);
        return;
      end
      exp_w = due_frames.pop_front();
      if (got.left_out !== exp_w.left_out || got.right_out !== exp_w.right_out ||
          got.last_output !== exp_w.last_output) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                   $signed(exp_w.left_out), $signed(exp_w.right_out), exp_w.last_output,
                   $signed(got.left_out), $signed(got.right_out), got.last_output);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic        pready;

  resample_tracker tracker = new();
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;

  logic [31:0] corner [N_CORNER] = '{
    {16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF}, {16'h0000, 16'h0000}, {16'hFFFF, 16'h0001},
    {16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000}, {16'h0001, 16'hFFFF}, {16'h5555, 16'hAAAA},
    {16'hAAAA, 16'h5555}, {16'h7FFF, 16'h8000}, {16'h0000, 16'hFFFF}, {16'h8000, 16'h0000},
    {16'h7FFF, 16'h0000}, {16'h8000, 16'h1234}, {16'h7FFF, 16'h8000}, {16'h0000, 16'h7FFF},
    {16'h8000, 16'h8000}, {16'h4000, 16'hC000},
    {16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF}, {16'h0000, 16'h0000}, {16'h7FFF, 16'h7FFF},
    {16'h8000, 16'h8000}, {16'h1234, 16'hEDCB}
  };

  linear_interp_audio_resampler_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // handshake monitor, checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) tracker.take_frame(in_data);
      if (out_valid && !out_stall) tracker.match_output(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // output side: random stall per word, plus one long hold-off on request
  initial begin : rx_side
    int k;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      k = rx_burst ? 0 : $urandom_range(0, 19);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic int draw_gap();
    return tx_burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input in_word_t w, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(input setting_t s);
    apb_write(REG_PHASE_INC, s.inc);
    apb_write(REG_MONO, {31'd0, s.mono});
    apb_write(REG_VOL_L, {16'd0, s.gain_l});
    apb_write(REG_VOL_R, {16'd0, s.gain_r});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every due word is out and the sequencer is back to idle
  task automatic drain();
    in_valid <= 1'b0;
    // let the monitor log the last accepted frame first
    @(posedge clk);
    while (tracker.due_frames.size() != 0 || in_stall) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  initial begin : stimulus
    setting_t s;
    in_word_t w;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: unit/negative gain, then small step with cap in mono, then max step
    configure('{32'h2800_0000, 1'b0, 16'h1000, 16'hF000});
    for (int i = 0; i < N_CORNER; i++) begin
      if (i == 12) begin
        drain();
        configure('{32'h0100_0000, 1'b1, 16'h7FFF, 16'h8000});
      end
      if (i == 18) begin
        drain();
        configure('{32'hFFFF_FFFF, 1'b0, 16'h8000, 16'h7FFF});
      end
      send_frame(in_word_t'(corner[i]), draw_gap());
    end
    drain();

    for (int p = 0; p < N_RAND_PHASES; p++) begin
      case (p)
        0: s = '{32'h4000_0000, 1'b0, 16'h1000, 16'h1000};
        1: s = '{32'h0800_0000, 1'b1, 16'h7FFF, 16'h8000};
        2: s = '{32'hFFFF_FFFF, 1'b0, 16'h8000, 16'h7FFF};
        3: s = '{32'h0400_0000, 1'b0, 16'($urandom), 16'($urandom)};
        default: s = '{$urandom_range(32'h0800_0000, 32'hFFFF_FFFF), 1'($urandom_range(0, 1)),
                       16'($urandom), 16'($urandom)};
      endcase
      configure(s);
      tx_burst = (p == 4) || ($urandom_range(0, 3) == 0);
      rx_burst = (p == 4) || ($urandom_range(0, 3) == 0);
      // eight words per frame here, so a long output hold backs up the input
      if (p == 1) hold_req = 1'b1;
      repeat (RAND_PER_PHASE) begin
        w.left_sample  = draw_sample();
        w.right_sample = draw_sample();
        send_frame(w, draw_gap());
      end
      drain();
    end

    if (tracker.mismatches == 0 && tracker.due_frames.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
